// ----- rtl/core/lgs_pkg.sv -----
// Shared constants and types for the life row generation step block.
package lgs_pkg;

   localparam int ROW_WIDTH = 16;
   localparam int HELD_WIDTH = 2;
   localparam int COUNT_WIDTH = 4;
   localparam logic [COUNT_WIDTH-1:0] BIRTH_COUNT = COUNT_WIDTH'(3);
   localparam logic [COUNT_WIDTH-1:0] STAY_COUNT = COUNT_WIDTH'(2);
   localparam logic [HELD_WIDTH-1:0] FULL_HELD = HELD_WIDTH'(2);

   typedef logic [ROW_WIDTH-1:0] row_type;

   typedef struct packed {
      row_type upper;
      row_type middle;
      row_type chance;
      logic    full;
   } window_type;

endpackage

// ----- rtl/core/lgs_window.sv -----
// Three-row window: holds the two previous rows, the chance bits of the middle row and the row count.
module lgs_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               start,
   input  lgs_pkg::row_type   row,
   input  lgs_pkg::row_type   chance,
   output lgs_pkg::window_type win
);
   import lgs_pkg::*;

   row_type                upper_ff, upper_in;
   row_type                middle_ff, middle_in;
   row_type                chance_ff, chance_in;
   logic [HELD_WIDTH-1:0]  held_ff, held_in;
   logic [HELD_WIDTH-1:0]  held_base;

   always_comb begin
      held_base = start ? '0 : held_ff;
      upper_in  = upper_ff;
      middle_in = middle_ff;
      chance_in = chance_ff;
      held_in   = held_ff;
      if (take) begin
         upper_in  = start ? '0 : middle_ff;
         middle_in = row;
         chance_in = chance;
         held_in   = (held_base >= FULL_HELD) ? FULL_HELD : held_base + HELD_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff  <= '0;
         middle_ff <= '0;
         chance_ff <= '0;
         held_ff   <= '0;
      end else begin
         upper_ff  <= upper_in;
         middle_ff <= middle_in;
         chance_ff <= chance_in;
         held_ff   <= held_in;
      end
   end

   assign win.upper  = upper_ff;
   assign win.middle = middle_ff;
   assign win.chance = chance_ff;
   assign win.full   = (held_ff >= FULL_HELD);

endmodule

// ----- rtl/core/lgs_lane.sv -----
// One cell lane: neighbour count and B3/S23 rule with chance gating.
module lgs_lane (
   input  logic [2:0] up,
   input  logic [2:0] mid,
   input  logic [2:0] low,
   input  logic       chance,
   output logic       next
);
   import lgs_pkg::*;

   logic [COUNT_WIDTH-1:0] count;

   always_comb begin
      count = COUNT_WIDTH'(up[0]) + COUNT_WIDTH'(up[1]) + COUNT_WIDTH'(up[2])
            + COUNT_WIDTH'(mid[0]) + COUNT_WIDTH'(mid[2])
            + COUNT_WIDTH'(low[0]) + COUNT_WIDTH'(low[1]) + COUNT_WIDTH'(low[2]);
      next = chance & ((count == BIRTH_COUNT) | (mid[1] & (count == STAY_COUNT)));
   end

endmodule

// ----- rtl/core/lgs_merge.sv -----
// Merge stage: gathers the lane outputs into the registered result row.
module lgs_merge (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic             emit,
   input  lgs_pkg::row_type lanes,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output lgs_pkg::row_type rsp_next_row,
   output logic             busy
);
   import lgs_pkg::*;

   logic    valid_ff, valid_in;
   row_type row_ff, row_in;

   always_comb begin
      valid_in = valid_ff;
      row_in   = row_ff;
      if (take && emit) begin
         valid_in = 1'b1;
         row_in   = lanes;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_next_row = row_ff;
   assign busy         = valid_ff & rsp_stall;

endmodule

// ----- rtl/core/life_row_generation_step.sv -----
// Top level of the life row generation step: window, cell lanes and merge stage.
//
//   channel  direction  transfer when          payload
//   req      in         req_valid & !req_stall row_cells, chance_mask, start_of_board
//   rsp      out        rsp_valid & !rsp_stall next_row
//
// One row per cycle unless req_stall is high; parallel lanes update all cells of a row.
// A result is registered from the row that completes a full window and appears in the cycle after.
// Reset is synchronous, active high, and empties the window and the result register.
// req_stall rises only while a result is held and rsp_stall is high.
module life_row_generation_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lgs_pkg::row_type req_row_cells,
   input  lgs_pkg::row_type req_chance_mask,
   input  logic             req_start_of_board,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lgs_pkg::row_type rsp_next_row
);
   import lgs_pkg::*;

   window_type win;
   row_type    lanes;
   logic       take;
   logic       emit;
   logic       busy;

   assign req_stall = busy;
   assign take      = req_valid & ~busy;
   assign emit      = win.full & ~req_start_of_board;

   lgs_window u_window (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .start  (req_start_of_board),
      .row    (req_row_cells),
      .chance (req_chance_mask),
      .win    (win)
   );

   for (genvar j = 0; j < ROW_WIDTH; j++) begin : g_lane
      localparam int L = (j == 0) ? ROW_WIDTH - 1 : j - 1;
      localparam int R = (j == ROW_WIDTH - 1) ? 0 : j + 1;
      lgs_lane u_lane (
         .up     ({win.upper[R], win.upper[j], win.upper[L]}),
         .mid    ({win.middle[R], win.middle[j], win.middle[L]}),
         .low    ({req_row_cells[R], req_row_cells[j], req_row_cells[L]}),
         .chance (win.chance[j]),
         .next   (lanes[j])
      );
   end

   lgs_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .emit         (emit),
      .lanes        (lanes),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_next_row (rsp_next_row),
      .busy         (busy)
   );

endmodule
